### hdl/byte_histogram_engine_top_defines.svh
// assertion macros for the byte histogram engine
// no dependencies; included by the modules that carry assertions
`ifndef BYTE_HISTOGRAM_ENGINE_TOP_DEFINES_SVH
`define BYTE_HISTOGRAM_ENGINE_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// checked property, disabled while reset is high
`define BHE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked property, also checked during reset
`define BHE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BHE_ASSERT(lbl, clk, rst, prop, msg)
`define BHE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### hdl/bhe_pkg.sv
// shared types, field widths and op codes of the byte histogram engine
// no dependencies; imported by the top level, front end and back end
package bhe_pkg;

   // default configuration
   localparam int DEF_NUM_BINS    = 256;
   localparam int DEF_COUNT_WIDTH = 32;

   // queue sizes
   localparam int WORK_Q_DEPTH = 2;

   // fixed field widths
   localparam int OP_W        = 2;
   localparam int KEY_W       = 8;
   localparam int WEIGHT_W    = 16;
   localparam int OUT_COUNT_W = 32;

   // op codes
   localparam logic [OP_W-1:0] OP_ACCUM      = 2'd0;
   localparam logic [OP_W-1:0] OP_READ       = 2'd1;
   localparam logic [OP_W-1:0] OP_READ_CLEAR = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE       = 2'd3;

   // one queued work item
   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [KEY_W-1:0]    key;
      logic [WEIGHT_W-1:0] weight;
   } bhe_item_type;

   // one result
   typedef struct packed {
      logic [KEY_W-1:0]       bin_index;
      logic [OUT_COUNT_W-1:0] bin_count;
      logic                   saturated;
   } bhe_rsp_type;

endpackage

### hdl/byte_histogram_engine_top.sv
// Byte histogram engine top level: front end, 2-entry work queue, bin update back end.
// A read result passes through the work queue, the execute state and the result queue before it is offered.
// Items are worked one at a time: each is fetched with a read of its bin, then written back, before the next.
// Reset: synchronous; a clearing pass zeroes every bin of the bin RAM, while
// up to two requests are queued and then held until the pass ends.
// Depends on bhe_pkg, bhe_front and bhe_back.
module byte_histogram_engine_top #(
   parameter int NUM_BINS    = bhe_pkg::DEF_NUM_BINS,
   parameter int COUNT_WIDTH = bhe_pkg::DEF_COUNT_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [bhe_pkg::OP_W-1:0]        req_op,
   input  logic [bhe_pkg::KEY_W-1:0]       req_key,
   input  logic [bhe_pkg::WEIGHT_W-1:0]    req_weight,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [bhe_pkg::KEY_W-1:0]       rsp_bin_index,
   output logic [bhe_pkg::OUT_COUNT_W-1:0] rsp_bin_count,
   output logic                            rsp_saturated
);
   import bhe_pkg::*;

   localparam int BIN_W = $clog2(NUM_BINS);

   bhe_item_type     req_item;
   bhe_item_type     item;
   logic [BIN_W-1:0] item_bin;
   logic             item_valid;
   logic             item_pop;
   bhe_rsp_type      rsp;

   assign req_item.op     = req_op;
   assign req_item.key    = req_key;
   assign req_item.weight = req_weight;

   bhe_front #(
      .NUM_BINS(NUM_BINS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_item  (req_item),
      .item_valid(item_valid),
      .item      (item),
      .item_bin  (item_bin),
      .item_pop  (item_pop)
   );

   bhe_back #(
      .NUM_BINS   (NUM_BINS),
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .item_valid(item_valid),
      .item      (item),
      .item_bin  (item_bin),
      .item_pop  (item_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp       (rsp)
   );

   assign rsp_bin_index = rsp.bin_index;
   assign rsp_bin_count = rsp.bin_count;
   assign rsp_saturated = rsp.saturated;

endmodule

### hdl/bhe_ram.sv
// generic single write port, single read port RAM with registered read data
// depends on nothing
module bhe_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### hdl/bhe_fifo.sv
// small register fifo used for the work queue and the result queue
// depends on nothing
module bhe_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] din,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] dout
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

### hdl/bhe_front.sv
// front end: accepts request transfers, drops unused op codes, maps key to bin
// depends on bhe_pkg and bhe_fifo
module bhe_front #(
   parameter int NUM_BINS = bhe_pkg::DEF_NUM_BINS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  bhe_pkg::bhe_item_type       req_item,
   output logic                        item_valid,
   output bhe_pkg::bhe_item_type       item,
   output logic [$clog2(NUM_BINS)-1:0] item_bin,
   input  logic                        item_pop
);
   import bhe_pkg::*;

   localparam int BIN_W  = $clog2(NUM_BINS);
   localparam int KEYS   = 1 << KEY_W;
   localparam int ITEM_W = $bits(bhe_item_type);
   localparam int QW     = ITEM_W + BIN_W;

   logic [BIN_W-1:0] bin_table [KEYS];
   logic [BIN_W-1:0] bin;
   logic [QW-1:0]    q_dout;
   logic             q_empty;
   logic             q_full;
   logic             q_push;

   // key modulo bin count as a fixed lookup over every key value
   for (genvar g = 0; g < KEYS; g++) begin : g_bin_map
      assign bin_table[g] = BIN_W'(g % NUM_BINS);
   end

   assign bin = bin_table[req_item.key];

   // unused op code is consumed without queuing
   assign q_push   = req_push && !q_full && (req_item.op != OP_NONE);
   assign req_full = q_full;

   bhe_fifo #(
      .WIDTH(QW),
      .DEPTH(WORK_Q_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push (q_push),
      .full (q_full),
      .din  ({req_item, bin}),
      .pop  (item_pop),
      .empty(q_empty),
      .dout (q_dout)
   );

   assign item_valid = !q_empty;
   assign item       = q_dout[QW-1:BIN_W];
   assign item_bin   = q_dout[BIN_W-1:0];

endmodule

### hdl/bhe_back.sv
// back end: read-modify-write of the bin RAM, clearing pass, result queue
// depends on bhe_pkg, bhe_ram, bhe_fifo and the assertion macro header
`include "byte_histogram_engine_top_defines.svh"
module bhe_back #(
   parameter int NUM_BINS    = bhe_pkg::DEF_NUM_BINS,
   parameter int COUNT_WIDTH = bhe_pkg::DEF_COUNT_WIDTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        item_valid,
   input  bhe_pkg::bhe_item_type       item,
   input  logic [$clog2(NUM_BINS)-1:0] item_bin,
   output logic                        item_pop,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output bhe_pkg::bhe_rsp_type        rsp
);
   import bhe_pkg::*;

   localparam int BIN_W = $clog2(NUM_BINS);
   localparam int EW    = COUNT_WIDTH + 1;
   localparam int SW    = ((COUNT_WIDTH > WEIGHT_W) ? COUNT_WIDTH : WEIGHT_W) + 1;
   localparam int RSP_W = $bits(bhe_rsp_type);
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [BIN_W-1:0]       clr_addr_ff, clr_addr_in;
   bhe_item_type           cur_ff, cur_in;
   logic [BIN_W-1:0]       cur_bin_ff, cur_bin_in;

   logic                   ram_we;
   logic [BIN_W-1:0]       ram_waddr;
   logic [EW-1:0]          ram_wdata;
   logic [EW-1:0]          ram_rdata;

   logic [COUNT_WIDTH-1:0] cur_count;
   logic                   cur_sat;
   logic [SW-1:0]          sum;
   logic                   over;
   logic                   is_read;
   logic                   out_full;
   logic                   out_push;
   logic                   start;
   bhe_rsp_type            out_din;

   // saturating add on the stored entry
   assign cur_count = ram_rdata[COUNT_WIDTH-1:0];
   assign cur_sat   = ram_rdata[COUNT_WIDTH];
   assign sum       = SW'(cur_count) + SW'(cur_ff.weight);
   assign over      = (sum > SW'(CNT_MAX));
   assign is_read   = (cur_ff.op == OP_READ) || (cur_ff.op == OP_READ_CLEAR);

   // an accumulate needs no result slot
   assign start    = item_valid && (!out_full || (item.op == OP_ACCUM));
   assign item_pop = (state_ff == ST_IDLE) && start;
   assign out_push = (state_ff == ST_EXEC) && is_read;

   // sequencer: clearing pass, then fetch and execute (update or read) one item at a time
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      cur_in      = cur_ff;
      cur_bin_in  = cur_bin_ff;
      ram_we      = 1'b0;
      ram_waddr   = cur_bin_ff;
      ram_wdata   = '0;
      case (state_ff)
         ST_CLEAR: begin
            ram_we      = 1'b1;
            ram_waddr   = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == BIN_W'(NUM_BINS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cur_in     = item;
               cur_bin_in = item_bin;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (cur_ff.op == OP_ACCUM) begin
               ram_we    = 1'b1;
               ram_wdata = over ? {1'b1, CNT_MAX} : {cur_sat, sum[COUNT_WIDTH-1:0]};
            end else if (cur_ff.op == OP_READ_CLEAR) begin
               ram_we    = 1'b1;
               ram_wdata = '0;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // item being worked on, no reset
   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      cur_bin_ff <= cur_bin_in;
   end

   // bin store: count in the low bits, sticky saturation flag on top
   bhe_ram #(
      .WIDTH(EW),
      .DEPTH(NUM_BINS)
   ) u_bins (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(item_bin),
      .rdata(ram_rdata)
   );

   // result queue decouples the bin update from the consumer
   assign out_din.bin_index = cur_ff.key;
   assign out_din.bin_count = OUT_COUNT_W'(cur_count);
   assign out_din.saturated = cur_sat;

   bhe_fifo #(
      .WIDTH(RSP_W),
      .DEPTH(2)
   ) u_results (
      .clock(clock),
      .reset(reset),
      .push (out_push),
      .full (out_full),
      .din  (out_din),
      .pop  (rsp_pop),
      .empty(rsp_empty),
      .dout (rsp)
   );

   `BHE_ASSERT(a_push_has_room, clock, reset, out_push |-> !out_full, "result queue overflow")
   `BHE_ASSERT(a_no_fetch_in_clear, clock, reset, (state_ff == ST_CLEAR) |-> !item_pop, "item fetched during clearing pass")
   `BHE_ASSERT(a_exec_after_fetch, clock, reset, item_pop |=> (state_ff == ST_EXEC), "fetched item not executed")
   `BHE_ASSERT_ALWAYS(a_clear_after_reset, clock, reset |=> (state_ff == ST_CLEAR), "reset did not start clearing pass")

endmodule
